[src/qbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_pkg
// shared types and constants of the quicksort buffer sorter
// ----------------------------------------------------------------------------
package qbs_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

endpackage

[src/qbs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_in_if
// input channel: one element word per handshake, last marks the end of a set
// ----------------------------------------------------------------------------
interface qbs_in_if;

    logic            valid;
    logic            ready;
    qbs_pkg::t_value value;
    logic            last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

[src/qbs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_out_if
// output channel: one sorted word per handshake with end and overflow flags
// ----------------------------------------------------------------------------
interface qbs_out_if;

    logic            valid;
    logic            ready;
    qbs_pkg::t_value sorted_value;
    logic            last_res;
    logic            overflow;

    modport source (output valid, output sorted_value, output last_res,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_res,
                    input overflow, output ready);

endinterface

[src/quicksort_buffer_sorter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_buffer_sorter_top
// buffers a set of signed words, sorts it in place by quicksort, streams it out
// ----------------------------------------------------------------------------
// Words load one per cycle into an element ram of DEPTH entries; words past
// DEPTH are dropped and flagged on every output word of that set. The word
// marked last closes the set and input stalls until the whole sorted set has
// been sent. The sort runs on the element ram's single read port: every
// pointer step of a partition reads and then compares, every swap writes
// both words back, and every range to sort is popped from the stack ram.
// Results then leave one at a time: each word is held on the output until
// it is taken, and only then is the next word captured. No clearing pass
// is needed after reset.
module quicksort_buffer_sorter_top #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qbs_in_if.sink    i_in,
    qbs_out_if.source o_out
);

    import qbs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 2 * IW;

    typedef enum logic [4:0] {
        S_LOAD,
        S_POP,
        S_POPW,
        S_PIV,
        S_SCANL_RD,
        S_SCANL_CK,
        S_SCANH_RD,
        S_SCANH_CK,
        S_SWAP_A,
        S_SWAP_B,
        S_FIN_A,
        S_FIN_B,
        S_PUSH_LO,
        S_PUSH_HI,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT_WAIT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_sp;
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [CW-1:0] r_lo;
    logic [IW-1:0] r_hi;
    logic [IW-1:0] r_k;
    t_value        r_pivot;
    t_value        r_vlo;
    t_value        r_vhi;
    logic          r_out_valid;
    t_value        r_out_data;
    logic          r_out_last;
    logic          r_out_ovf;

    // element ram ports
    logic              w_mem_we;
    logic [IW-1:0]     w_mem_waddr;
    logic [VALUE_W-1:0] w_mem_wdata;
    logic [IW-1:0]     w_mem_raddr;
    logic [VALUE_W-1:0] w_mem_rdata;
    t_value            w_rd;

    // stack ram ports
    logic          w_stk_we;
    logic [IW-1:0] w_stk_waddr;
    logic [SW-1:0] w_stk_wdata;
    logic [IW-1:0] w_stk_raddr;
    logic [SW-1:0] w_stk_rdata;

    logic          w_in_acc;
    logic          w_has_room;
    logic [CW-1:0] w_count_new;
    logic [CW-1:0] w_hi_ext;
    logic [CW-1:0] w_head_ext;
    logic [CW-1:0] w_tail_ext;
    logic          w_push_lo;
    logic          w_push_hi;
    logic          w_stk_room;
    logic [IW-1:0] w_hi_dec;
    logic [IW-1:0] w_hi_inc;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_has_room  = (r_count < CW'(DEPTH));
    assign w_count_new = w_has_room ? (r_count + CW'(1)) : r_count;
    assign w_rd        = $signed(w_mem_rdata);
    assign w_hi_ext    = {1'b0, r_hi};
    assign w_head_ext  = {1'b0, r_head};
    assign w_tail_ext  = {1'b0, r_tail};
    assign w_stk_room  = (r_sp < CW'(DEPTH));
    assign w_push_lo   = (w_hi_ext > (w_head_ext + CW'(1))) && w_stk_room;
    assign w_push_hi   = ((w_hi_ext + CW'(1)) < w_tail_ext) && w_stk_room;
    assign w_hi_dec    = r_hi - IW'(1);
    assign w_hi_inc    = r_hi + IW'(1);

    // element ram write and read address
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_count[IW-1:0];
        w_mem_wdata = i_in.value;
        w_mem_raddr = r_lo[IW-1:0];
        case (r_state)
            S_LOAD: begin
                w_mem_we = w_in_acc && w_has_room;
            end
            S_POPW: begin
                w_mem_raddr = w_stk_rdata[SW-1:IW];
            end
            S_SCANL_RD: begin
                w_mem_raddr = r_lo[IW-1:0];
            end
            S_SCANH_RD: begin
                w_mem_raddr = r_hi;
            end
            S_SWAP_A: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_lo[IW-1:0];
                w_mem_wdata = r_vhi;
            end
            S_SWAP_B: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_hi;
                w_mem_wdata = r_vlo;
            end
            S_FIN_A: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_head;
                w_mem_wdata = r_vhi;
            end
            S_FIN_B: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_hi;
                w_mem_wdata = r_pivot;
            end
            S_OUT_RD: begin
                w_mem_raddr = r_k;
            end
            S_OUT_WAIT: begin
                w_mem_raddr = r_k + IW'(1);
            end
            default: begin
                w_mem_raddr = r_lo[IW-1:0];
            end
        endcase
    end

    // stack ram write and read address
    always_comb begin
        w_stk_we    = 1'b0;
        w_stk_waddr = r_sp[IW-1:0];
        w_stk_wdata = {r_head, w_hi_dec};
        w_stk_raddr = w_stk_waddr - IW'(1);
        case (r_state)
            S_LOAD: begin
                w_stk_we    = w_in_acc && i_in.last && (w_count_new > CW'(1));
                w_stk_waddr = '0;
                w_stk_wdata = {IW'(0), w_count_new[IW-1:0] - IW'(1)};
            end
            S_PUSH_LO: begin
                w_stk_we    = w_push_lo;
                w_stk_wdata = {r_head, w_hi_dec};
            end
            S_PUSH_HI: begin
                w_stk_we    = w_push_hi;
                w_stk_wdata = {w_hi_inc, r_tail};
            end
            default: begin
                w_stk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        r_count <= w_count_new;
                        if (!w_has_room) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.last) begin
                            if (w_count_new > CW'(1)) begin
                                r_sp    <= CW'(1);
                                r_state <= S_POP;
                            end else begin
                                r_k     <= '0;
                                r_state <= S_OUT_RD;
                            end
                        end
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_k     <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_sp    <= r_sp - CW'(1);
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    r_head  <= w_stk_rdata[SW-1:IW];
                    r_tail  <= w_stk_rdata[IW-1:0];
                    r_state <= S_PIV;
                end
                S_PIV: begin
                    r_pivot <= w_rd;
                    r_lo    <= w_head_ext + CW'(1);
                    r_hi    <= r_tail;
                    r_state <= S_SCANL_RD;
                end
                S_SCANL_RD: begin
                    r_state <= S_SCANL_CK;
                end
                S_SCANL_CK: begin
                    if ((r_lo < w_tail_ext) && (w_rd < r_pivot)) begin
                        r_lo    <= r_lo + CW'(1);
                        r_state <= S_SCANL_RD;
                    end else begin
                        r_vlo   <= w_rd;
                        r_state <= S_SCANH_RD;
                    end
                end
                S_SCANH_RD: begin
                    r_state <= S_SCANH_CK;
                end
                S_SCANH_CK: begin
                    if ((r_hi > r_head) && (r_pivot < w_rd)) begin
                        r_hi    <= w_hi_dec;
                        r_state <= S_SCANH_RD;
                    end else begin
                        r_vhi <= w_rd;
                        if (r_lo >= w_hi_ext) begin
                            r_state <= S_FIN_A;
                        end else begin
                            r_state <= S_SWAP_A;
                        end
                    end
                end
                S_SWAP_A: begin
                    r_state <= S_SWAP_B;
                end
                S_SWAP_B: begin
                    r_lo    <= r_lo + CW'(1);
                    r_hi    <= w_hi_dec;
                    r_state <= S_SCANL_RD;
                end
                S_FIN_A: begin
                    r_state <= S_FIN_B;
                end
                S_FIN_B: begin
                    r_state <= S_PUSH_LO;
                end
                S_PUSH_LO: begin
                    if (w_push_lo) begin
                        r_sp <= r_sp + CW'(1);
                    end
                    r_state <= S_PUSH_HI;
                end
                S_PUSH_HI: begin
                    if (w_push_hi) begin
                        r_sp <= r_sp + CW'(1);
                    end
                    r_state <= S_POP;
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_CAP;
                end
                S_OUT_CAP: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= w_rd;
                    r_out_last  <= (({1'b0, r_k} + CW'(1)) == r_count);
                    r_out_ovf   <= r_ovf;
                    r_state     <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + IW'(1);
                            r_state <= S_OUT_CAP;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    qbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    qbs_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    assign i_in.ready         = (r_state == S_LOAD);
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_data;
    assign o_out.last_res     = r_out_last;
    assign o_out.overflow     = r_out_ovf;

    logic w_in_part;
    assign w_in_part = (r_state == S_SCANL_CK) || (r_state == S_SCANH_CK)
                    || (r_state == S_SWAP_A) || (r_state == S_SWAP_B);

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input open while an output word is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(DEPTH)) && (r_sp <= CW'(DEPTH)))
        else $error("element count or stack pointer out of range");

    a_hi_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_part |-> ((r_hi >= r_head) && (r_hi <= r_tail)))
        else $error("partition high pointer left its range");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_res) |=> (i_in.ready && (r_count == '0)))
        else $error("set not cleared after final word");

endmodule

[src/qbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module qbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[dv/qbs_sort_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_sort_checker
// watches both channels of the quicksort buffer sorter and checks its output
// ----------------------------------------------------------------------------
// Collects every accepted input word of a set, dropping words past DEPTH and
// noting the overflow. When the word marked last is accepted, the kept words
// are put in ascending signed order, and one expected sorted word per kept
// element is queued with its end and overflow flags. Each accepted output word
// is compared with the oldest queued word. The failure count and the number of
// words still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module qbs_sort_checker #(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qbs_in_if    i_in_mon,
    qbs_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_words_due
);

    import qbs_pkg::*;

    typedef struct packed {
        t_value value;
        logic   last_res;
        logic   overflow;
    } t_sorted_word;

    t_value       set_words[$];
    bit           set_overflow;
    t_sorted_word sorted_words_due[$];
    t_sorted_word got;
    t_sorted_word want;
    t_value       key;
    int           i;
    int           j;
    int           set_size;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_words.delete();
            set_overflow = 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (set_words.size() < DEPTH) begin
                    set_words.push_back(i_in_mon.value);
                end else begin
                    set_overflow = 1;
                end
                if (i_in_mon.last) begin
                    set_size = set_words.size();
                    // ascending signed order
                    for (i = 1; i < set_size; i++) begin
                        key = set_words[i];
                        j   = i - 1;
                        while (j >= 0 && set_words[j] > key) begin
                            set_words[j+1] = set_words[j];
                            j--;
                        end
                        set_words[j+1] = key;
                    end
                    for (i = 0; i < set_size; i++) begin
                        sorted_words_due.push_back(t_sorted_word'{set_words[i],
                                                   (i == set_size - 1), set_overflow});
                    end
                    set_words.delete();
                    set_overflow = 0;
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.sorted_value, i_out_mon.last_res, i_out_mon.overflow};
                if (sorted_words_due.size() == 0) begin
                    $display("%0t qbs: unexpected word, expected none,", $time,
                             " actual value %0d last %0b overflow %0b",
                             got.value, got.last_res, got.overflow);
                    o_fail_count++;
                end else begin
                    want = sorted_words_due.pop_front();
                    if (got !== want) begin
                        $display("%0t qbs: mismatch,", $time,
                                 " expected value %0d last %0b overflow %0b,",
                                 want.value, want.last_res, want.overflow,
                                 " actual value %0d last %0b overflow %0b",
                                 got.value, got.last_res, got.overflow);
                        o_fail_count++;
                    end
                end
            end
        end
        o_words_due = sorted_words_due.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the quicksort buffer sorter
// ----------------------------------------------------------------------------
// Sends a few hand-picked sets first: a lone word, a pair, the signed extremes
// with repeats, and short ascending and descending runs. Then random sets of
// mostly small size with random, narrow, ordered, reversed and constant
// contents, one set that overruns the buffer and one that fills it exactly.
// Both sides stall in random bursts until the last part of the run. The
// checker beside the block predicts and compares every sorted word.
// ----------------------------------------------------------------------------
module tb;

    import qbs_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_WORDS = 256;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_ASCENDING,
        FILL_DESCENDING,
        FILL_CONSTANT
    } t_fill;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     words_due;
    bit     quiet_phase;
    int     ready_hold;
    int     words_sent;
    int     set_idx;
    int     set_size;
    int     pick;
    t_fill  fill;
    t_value extremes[10] = '{0, -1, 32'sh80000000, 32'sh7fffffff, 1,
                             -1, 32'sh80000000, 0, 32'sh7fffffff, 42};

    qbs_in_if  in_ch ();
    qbs_out_if out_ch ();

    quicksort_buffer_sorter_top #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    qbs_sort_checker #(
        .DEPTH (DEPTH)
    ) u_sort_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    initial i_clk = 0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            out_ch.ready = 0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            ready_hold   = $urandom_range(1, 10) - 1;
            out_ch.ready = 0;
        end else begin
            out_ch.ready = 1;
        end
    end

    task automatic send_word(input t_value v, input logic is_last);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap         = $urandom_range(1, 10);
            in_ch.valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1;
        in_ch.value = v;
        in_ch.last  = is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_set(input int size, input t_fill f);
        t_value base;
        t_value v;
        int     k;
        base = $urandom;
        for (k = 0; k < size; k++) begin
            case (f)
                FILL_RANDOM:     v = $urandom;
                FILL_NARROW:     v = $signed($urandom_range(0, 6)) - 3;
                FILL_ASCENDING:  v = (base >>> 8) + k;
                FILL_DESCENDING: v = (base >>> 8) - k;
                default:         v = base;
            endcase
            send_word(v, k == size - 1);
        end
    endtask

    initial begin
        in_ch.valid  = 0;
        in_ch.value  = '0;
        in_ch.last   = 0;
        i_rst_n      = 0;
        quiet_phase  = 0;
        words_sent   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_word(32'sh7fffffff, 1);
        send_word(5, 0);
        send_word(-5, 1);
        foreach (extremes[k]) send_word(extremes[k], k == 9);
        send_set(6, FILL_ASCENDING);
        send_set(6, FILL_DESCENDING);

        words_sent = 0;
        set_idx    = 0;
        while (words_sent < RANDOM_WORDS) begin
            quiet_phase = (words_sent >= RANDOM_WORDS * 4 / 5);
            if (set_idx == 2) begin
                set_size = DEPTH + $urandom_range(1, 6);
            end else if (set_idx == 9) begin
                set_size = DEPTH;
            end else begin
                set_size = $urandom_range(1, 12);
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)       fill = FILL_RANDOM;
            else if (pick < 7)  fill = FILL_NARROW;
            else if (pick == 7) fill = FILL_ASCENDING;
            else if (pick == 8) fill = FILL_DESCENDING;
            else                fill = FILL_CONSTANT;
            send_set(set_size, fill);
            set_idx++;
        end
        in_ch.valid = 0;
        quiet_phase = 1;

        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
